// ----- design/lds_pkg.sv -----
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types, codes and default sizes for the linked deque with key delete.
// ----------------------------------------------------------------------------
package lds_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_VALUE_BITS = 32;

   // Request actions.
   localparam logic [2:0] ACT_INSERT     = 3'd0;
   localparam logic [2:0] ACT_DELETE_KEY = 3'd1;
   localparam logic [2:0] ACT_DEL_FIRST  = 3'd2;
   localparam logic [2:0] ACT_DEL_LAST   = 3'd3;
   localparam logic [2:0] ACT_DUMP       = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] item;
      logic               is_last;
   } rsp_type;

   // Write enables from the sequencer to the memories.
   typedef struct packed {
      logic value_we;
      logic next_we;
      logic prev_we;
   } mem_ctl_type;

endpackage

// ----- design/lds_value_ram.sv -----
// ----------------------------------------------------------------------------
// lds_value_ram
// Value store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lds_value_ram
   import lds_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   localparam int IW        = $clog2(CAPACITY)
) (
   input  logic                  clock,
   input  mem_ctl_type           mem_ctl,
   input  logic [IW-1:0]         wr_addr,
   input  logic [VALUE_BITS-1:0] wr_data,
   input  logic [IW-1:0]         rd_addr,
   output logic [VALUE_BITS-1:0] rd_data
);

   logic [VALUE_BITS-1:0] value_mem [CAPACITY];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.value_we) begin
         value_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= value_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lds_link_ram.sv -----
// ----------------------------------------------------------------------------
// lds_link_ram
// Next and previous link stores with a shared read address. Per-entry valid
// bits give the reset contents: next links chained as a free list, prev zero.
// ----------------------------------------------------------------------------
module lds_link_ram
   import lds_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY,
   localparam int IW      = $clog2(CAPACITY)
) (
   input  logic          clock,
   input  logic          reset,
   input  mem_ctl_type   mem_ctl,
   input  logic [IW-1:0] rd_addr,
   input  logic [IW-1:0] next_wr_addr,
   input  logic [IW-1:0] next_wr_data,
   input  logic [IW-1:0] prev_wr_addr,
   input  logic [IW-1:0] prev_wr_data,
   output logic [IW-1:0] next_rd_data,
   output logic [IW-1:0] prev_rd_data
);

   logic [IW-1:0]       next_mem [CAPACITY];
   logic [IW-1:0]       prev_mem [CAPACITY];
   logic [CAPACITY-1:0] next_vld_ff;
   logic [CAPACITY-1:0] prev_vld_ff;
   logic [IW-1:0]       next_rd_ff;
   logic [IW-1:0]       prev_rd_ff;
   logic                next_rv_ff;
   logic                prev_rv_ff;
   logic [IW-1:0]       rd_addr_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.next_we) begin
         next_mem[next_wr_addr] <= next_wr_data;
      end
      if (mem_ctl.prev_we) begin
         prev_mem[prev_wr_addr] <= prev_wr_data;
      end
      next_rd_ff <= next_mem[rd_addr];
      prev_rd_ff <= prev_mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_vld_ff <= '0;
         prev_vld_ff <= '0;
         next_rv_ff  <= 1'b0;
         prev_rv_ff  <= 1'b0;
      end else begin
         if (mem_ctl.next_we) begin
            next_vld_ff[next_wr_addr] <= 1'b1;
         end
         if (mem_ctl.prev_we) begin
            prev_vld_ff[prev_wr_addr] <= 1'b1;
         end
         next_rv_ff <= next_vld_ff[rd_addr];
         prev_rv_ff <= prev_vld_ff[rd_addr];
      end
   end

   // An entry never written holds its reset link.
   assign next_rd_data = next_rv_ff ? next_rd_ff : IW'(rd_addr_ff + 1'b1);
   assign prev_rd_data = prev_rv_ff ? prev_rd_ff : '0;

endmodule

// ----- design/lds_ctrl.sv -----
// ----------------------------------------------------------------------------
// lds_ctrl
// Sequencer: holds the end pointers, free head and count, walks the chain
// one entry a cycle and issues the read-modify-write steps of each action.
// ----------------------------------------------------------------------------
module lds_ctrl
   import lds_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   localparam int IW        = $clog2(CAPACITY),
   localparam int CW        = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  req_type               req_data,
   output logic                  busy,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   output mem_ctl_type           mem_ctl,
   output logic [IW-1:0]         rd_addr,
   output logic [IW-1:0]         next_wr_addr,
   output logic [IW-1:0]         next_wr_data,
   output logic [IW-1:0]         prev_wr_addr,
   output logic [IW-1:0]         prev_wr_data,
   output logic [IW-1:0]         value_wr_addr,
   output logic [VALUE_BITS-1:0] value_wr_data,
   input  logic [IW-1:0]         next_rd_data,
   input  logic [IW-1:0]         prev_rd_data,
   input  logic [VALUE_BITS-1:0] value_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_SRCH,
      S_DUMP,
      S_UNL_A,
      S_UNL_B
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [IW-1:0]         ptr_ff, ptr_in;
   logic [CW-1:0]         step_ff, step_in;
   logic [IW-1:0]         front_ff, front_in;
   logic [IW-1:0]         back_ff, back_in;
   logic [IW-1:0]         free_ff, free_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  walk_last;

   assign walk_last = (step_ff + CW'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      ptr_in        = ptr_ff;
      step_in       = step_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in.status  = ST_OK;
      rsp_in.item    = '0;
      rsp_in.is_last = 1'b1;
      mem_ctl       = '0;
      rd_addr       = ptr_ff;
      next_wr_addr  = ptr_ff;
      next_wr_data  = free_ff;
      prev_wr_addr  = front_ff;
      prev_wr_data  = free_ff;
      value_wr_addr = free_ff;
      value_wr_data = key_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in  = VALUE_BITS'(req_data.value);
               step_in = '0;
               unique case (req_data.action) inside
                  ACT_INSERT: begin
                     rd_addr = free_ff;
                     if (count_ff == CW'(CAPACITY)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_FULL;
                     end else begin
                        // The old front learns its new predecessor now; the
                        // new entry itself is written once its next link is read.
                        mem_ctl.prev_we = (count_ff != '0);
                        state_in        = S_INS;
                     end
                  end
                  ACT_DELETE_KEY, ACT_DUMP: begin
                     rd_addr = front_ff;
                     ptr_in  = front_ff;
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        state_in = (req_data.action == ACT_DUMP) ? S_DUMP : S_SRCH;
                     end
                  end
                  ACT_DEL_FIRST, ACT_DEL_LAST: begin
                     rd_addr = (req_data.action == ACT_DEL_LAST) ? back_ff : front_ff;
                     ptr_in  = rd_addr;
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_UNL_A;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS: begin
            free_in         = next_rd_data;
            mem_ctl.value_we = 1'b1;
            mem_ctl.next_we  = 1'b1;
            mem_ctl.prev_we  = 1'b1;
            next_wr_addr    = free_ff;
            next_wr_data    = (count_ff == '0) ? '0 : front_ff;
            prev_wr_addr    = free_ff;
            prev_wr_data    = '0;
            front_in        = free_ff;
            if (count_ff == '0) begin
               back_in = free_ff;
            end
            count_in      = count_ff + CW'(1);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_SRCH: begin
            if (value_rd_data == key_ff) begin
               rd_addr  = ptr_ff;
               state_in = S_UNL_A;
            end else if (walk_last) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = ST_EMPTY;
               state_in      = S_IDLE;
            end else begin
               rd_addr = next_rd_data;
               ptr_in  = next_rd_data;
               step_in = step_ff + CW'(1);
            end
         end
         S_DUMP: begin
            rsp_strobe_in  = 1'b1;
            rsp_in.item    = 32'(value_rd_data);
            rsp_in.is_last = walk_last;
            if (walk_last) begin
               state_in = S_IDLE;
            end else begin
               rd_addr = next_rd_data;
               ptr_in  = next_rd_data;
               step_in = step_ff + CW'(1);
            end
         end
         S_UNL_A: begin
            // Only a middle entry relinks its neighbors; an end entry just
            // moves the end pointer, if any entry remains, and leaves the stale link in place.
            if (count_ff > CW'(1)) begin
               if (ptr_ff == front_ff) begin
                  front_in = next_rd_data;
               end else if (ptr_ff == back_ff) begin
                  back_in = prev_rd_data;
               end else begin
                  mem_ctl.next_we = 1'b1;
                  mem_ctl.prev_we = 1'b1;
                  next_wr_addr    = prev_rd_data;
                  next_wr_data    = next_rd_data;
                  prev_wr_addr    = next_rd_data;
                  prev_wr_data    = prev_rd_data;
               end
            end
            state_in = S_UNL_B;
         end
         S_UNL_B: begin
            mem_ctl.next_we = 1'b1;
            next_wr_addr    = ptr_ff;
            next_wr_data    = free_ff;
            free_in         = ptr_ff;
            count_in        = count_ff - CW'(1);
            rsp_strobe_in   = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         back_ff       <= '0;
         free_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         back_ff       <= back_in;
         free_ff       <= free_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      key_ff  <= key_in;
      ptr_ff  <= ptr_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- design/linked_deque_with_key_delete.sv -----
// ----------------------------------------------------------------------------
// linked_deque_with_key_delete
// Bounded doubly linked deque of signed values held in on-chip memories.
//
//   channel   ports                         transfer
//   request   start, busy, req_data         start high while busy low
//   result    rsp_strobe, rsp_data          one-cycle strobe per word, no stall
//
// Insert writes its entry in S_INS and delete-first/last unlink in S_UNL_A
// and S_UNL_B before the word is registered. Key delete walks one entry per
// cycle through the link memory read port, then unlinks in the same states.
// Dump shows one word per cycle once the front entry has been read.
// Reset is synchronous; the link stores come up at once through valid bits.
// busy stays high until the final word of a request is registered.
// ----------------------------------------------------------------------------
module linked_deque_with_key_delete
   import lds_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(CAPACITY);

   mem_ctl_type           mem_ctl;
   logic [IW-1:0]         rd_addr;
   logic [IW-1:0]         next_wr_addr;
   logic [IW-1:0]         next_wr_data;
   logic [IW-1:0]         prev_wr_addr;
   logic [IW-1:0]         prev_wr_data;
   logic [IW-1:0]         value_wr_addr;
   logic [VALUE_BITS-1:0] value_wr_data;
   logic [IW-1:0]         next_rd_data;
   logic [IW-1:0]         prev_rd_data;
   logic [VALUE_BITS-1:0] value_rd_data;

   lds_ctrl #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_data      (req_data),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .mem_ctl       (mem_ctl),
      .rd_addr       (rd_addr),
      .next_wr_addr  (next_wr_addr),
      .next_wr_data  (next_wr_data),
      .prev_wr_addr  (prev_wr_addr),
      .prev_wr_data  (prev_wr_data),
      .value_wr_addr (value_wr_addr),
      .value_wr_data (value_wr_data),
      .next_rd_data  (next_rd_data),
      .prev_rd_data  (prev_rd_data),
      .value_rd_data (value_rd_data)
   );

   lds_link_ram #(
      .CAPACITY (CAPACITY)
   ) u_link_ram (
      .clock        (clock),
      .reset        (reset),
      .mem_ctl      (mem_ctl),
      .rd_addr      (rd_addr),
      .next_wr_addr (next_wr_addr),
      .next_wr_data (next_wr_data),
      .prev_wr_addr (prev_wr_addr),
      .prev_wr_data (prev_wr_data),
      .next_rd_data (next_rd_data),
      .prev_rd_data (prev_rd_data)
   );

   lds_value_ram #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_value_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (value_wr_addr),
      .wr_data (value_wr_data),
      .rd_addr (rd_addr),
      .rd_data (value_rd_data)
   );

endmodule

// ----- design/lds_checker.sv -----
// ----------------------------------------------------------------------------
// lds_checker
// Port-level checks on the deque's result timing, bound to the top level.
// ----------------------------------------------------------------------------
module lds_checker
   import lds_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // The block comes out of reset idle and silent.
   assert property (@(posedge clock) $past(reset) |-> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   // Every word follows a request that was taken or still in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || start))
      else $error("result word without a request");

   // A word that is not the last of its request comes while busy with OK status and is followed at once by another.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.is_last) |-> (busy && rsp_data.status == ST_OK))
      else $error("non-final word while idle or with error status");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.is_last) |=> rsp_strobe)
      else $error("dump stream interrupted");

   // Error status words carry no item and end their request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> (rsp_data.is_last && rsp_data.item == 0))
      else $error("error word not final or carries an item");

endmodule

bind linked_deque_with_key_delete lds_checker u_checker (.*);
